// ===== hw/rtl/lbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lbs_pkg;

  localparam int SLOT_W = 12;
  localparam int DATA_W = 32;
  // matrix elements actually used per bone: rows 0..3, columns 0..2
  localparam int ELEMS  = 12;
  localparam int ELEM_W = 4;
  localparam int TRANS_BASE = 9;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_SKIN  = 1'b1;

  // sum >= 255 * 2^31 or sum < -255 * 2^31 saturates after the divide by 255
  localparam logic [63:0] SAT_BOUND = 64'd255 << 31;
  localparam int DIV_W = 39;

  localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] data;
  } pal_wr_t;

endpackage
`default_nettype wire

// ===== hw/rtl/lbs_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface lbs_in_if import lbs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               op;
  logic [SLOT_W-1:0]  matrix_slot;
  logic signed [31:0] matrix_value;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] norm_x;
  logic signed [31:0] norm_y;
  logic signed [31:0] norm_z;
  logic [31:0]        bone_indices;
  logic [31:0]        bone_weights;
  logic               last_vertex;

  modport source (output valid, op, matrix_slot, matrix_value, pos_x, pos_y, pos_z,
                  norm_x, norm_y, norm_z, bone_indices, bone_weights, last_vertex,
                  input ready);
  modport sink (input valid, op, matrix_slot, matrix_value, pos_x, pos_y, pos_z,
                norm_x, norm_y, norm_z, bone_indices, bone_weights, last_vertex,
                output ready);
endinterface

interface lbs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] skin_pos_x;
  logic signed [31:0] skin_pos_y;
  logic signed [31:0] skin_pos_z;
  logic signed [31:0] skin_norm_x;
  logic signed [31:0] skin_norm_y;
  logic signed [31:0] skin_norm_z;
  logic               end_of_mesh;

  modport source (output valid, skin_pos_x, skin_pos_y, skin_pos_z, skin_norm_x,
                  skin_norm_y, skin_norm_z, end_of_mesh, input ready);
  modport sink (input valid, skin_pos_x, skin_pos_y, skin_pos_z, skin_norm_x,
                skin_norm_y, skin_norm_z, end_of_mesh, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/lbs_palette.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lbs_palette import lbs_pkg::*; #(
  parameter int BONE_COUNT = 256,
  parameter int INFLUENCES = 4,
  parameter int AW = 8
) (
  input  wire logic          clk,
  input  wire pal_wr_t       wr,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_bone [INFLUENCES],
  output logic [DATA_W-1:0]  rd_data [INFLUENCES][ELEMS]
);

  logic [7:0]        wbone;
  logic [1:0]        wrow;
  logic [1:0]        wcol;
  logic              wok;
  logic [ELEM_W-1:0] welem;

  always_comb begin
    wbone = wr.slot[11:4];
    wrow  = wr.slot[3:2];
    wcol  = wr.slot[1:0];
    // column 3 is never read, so it is not stored
    wok   = wr.en && ({1'b0, wbone} < 9'(BONE_COUNT)) && (wcol != 2'd3);
    welem = ELEM_W'({2'b00, wrow} * 4'd3) + {2'b00, wcol};
  end

  // one bank per used element, copied once per influence for parallel reads
  for (genvar k = 0; k < INFLUENCES; k++) begin : g_inf
    for (genvar e = 0; e < ELEMS; e++) begin : g_elem
      logic [DATA_W-1:0] mem [BONE_COUNT];
      logic [DATA_W-1:0] q;
      always_ff @(posedge clk) begin
        if (wok && welem == ELEM_W'(e)) mem[wbone[AW-1:0]] <= wr.data;
        // an index past the palette reads as zero
        if (rd_en) q <= ({1'b0, rd_bone[k]} < (AW+1)'(BONE_COUNT)) ? mem[rd_bone[k]] : '0;
      end
      assign rd_data[k][e] = q;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/lbs_xform.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lbs_xform import lbs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic [2:0]         adv,
  input  wire logic [DATA_W-1:0]  elem [ELEMS],
  input  wire logic signed [31:0] pos [3],
  input  wire logic signed [31:0] nrm [3],
  input  wire logic [7:0]         w,
  output logic signed [63:0]      term_p [3],
  output logic signed [63:0]      term_n [3]
);

  localparam int PW = 64 - FRAC_BITS;
  localparam int SW = PW + 2;

  logic signed [63:0] full_p [3][3];
  logic signed [63:0] full_n [3][3];
  logic signed [PW-1:0] pp [3][3];
  logic signed [PW-1:0] pn [3][3];
  logic signed [31:0]   trans [3];
  logic [7:0]           w2;
  logic [7:0]           w3;
  logic signed [SW-1:0] tp [3];
  logic signed [SW-1:0] tn [3];
  logic signed [8:0]    ws;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        full_p[j][i] = pos[i] * $signed(elem[i*3 + j]);
        full_n[j][i] = nrm[i] * $signed(elem[i*3 + j]);
      end
    end
    ws = $signed({1'b0, w3});
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          // arithmetic shift floors toward minus infinity
          pp[j][i] <= PW'(full_p[j][i] >>> FRAC_BITS);
          pn[j][i] <= PW'(full_n[j][i] >>> FRAC_BITS);
        end
        trans[j] <= $signed(elem[TRANS_BASE + j]);
      end
      w2 <= w;
    end
    if (adv[1]) begin
      for (int j = 0; j < 3; j++) begin
        tp[j] <= SW'(pp[j][0]) + SW'(pp[j][1]) + SW'(pp[j][2]) + SW'(trans[j]);
        tn[j] <= SW'(pn[j][0]) + SW'(pn[j][1]) + SW'(pn[j][2]);
      end
      w3 <= w2;
    end
    if (adv[2]) begin
      for (int j = 0; j < 3; j++) begin
        term_p[j] <= 64'(tp[j]) * 64'(ws);
        term_n[j] <= 64'(tn[j]) * 64'(ws);
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/lbs_norm.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lbs_norm import lbs_pkg::*; (
  input  wire logic               clk,
  input  wire logic [1:0]         adv,
  input  wire logic signed [63:0] acc,
  output logic signed [31:0]      res
);

  logic              sgn;
  logic [63:0]       y;
  logic [DIV_W-1:0]  r0;
  logic [30:0]       a1;
  logic [31:0]       r1;
  logic [23:0]       a2;
  logic [24:0]       r2;
  logic [31:0]       q2;
  logic              sgn6;
  logic              sat6;
  logic [31:0]       q6;
  logic [24:0]       r6;
  logic [16:0]       a3;
  logic [17:0]       r3;
  logic [9:0]        a4;
  logic [10:0]       r4;
  logic [31:0]       q;

  // floor(x/255) for negative x is ~(~x / 255), so work on the magnitude
  always_comb begin
    sgn = acc[63];
    y   = acc ^ {64{sgn}};
    r0  = y[DIV_W-1:0];
    // 256 = 255 + 1: fold the high digit back into the remainder
    a1  = r0[DIV_W-1:8];
    r1  = {1'b0, a1} + {24'd0, r0[7:0]};
    a2  = r1[31:8];
    r2  = {1'b0, a2} + {17'd0, r1[7:0]};
    q2  = {1'b0, a1} + {8'd0, a2};
    a3  = r6[24:8];
    r3  = {1'b0, a3} + {10'd0, r6[7:0]};
    a4  = r3[17:8];
    r4  = {1'b0, a4} + {3'd0, r3[7:0]};
    q   = q6 + {15'd0, a3} + {22'd0, a4} + {31'd0, (r4 >= 11'd255)};
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      sgn6 <= sgn;
      sat6 <= (y >= SAT_BOUND);
      q6   <= q2;
      r6   <= r2;
    end
    if (adv[1]) begin
      if (sat6) res <= sgn6 ? INT_MIN : INT_MAX;
      else      res <= $signed(q ^ {32{sgn6}});
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/linear_blend_skinning_vertex.sv =====
// throughput: one vertex per cycle unless an output stall fills the pipeline;
// a palette write takes an input slot just as a vertex does
// a palette write is visible to the vertex accepted in the next cycle
// stages: palette read, products, row sums, weighting, blend sum, two divide steps
// rst (synchronous) empties the pipeline; palette contents are kept, not cleared
`timescale 1ns / 1ps
`default_nettype none
module linear_blend_skinning_vertex import lbs_pkg::*; #(
  parameter int BONE_COUNT = 256,
  parameter int INFLUENCES = 4,
  parameter int FRAC_BITS  = 16
) (
  input wire logic clk,
  input wire logic rst,
  lbs_in_if.sink   vin,
  lbs_out_if.source vout
);

  localparam int NS = 7;
  localparam int AW = (BONE_COUNT > 1) ? $clog2(BONE_COUNT) : 1;

  logic [NS:1]   v;
  logic [NS+1:1] en;
  logic [NS:1]   last_q;

  pal_wr_t            pal_wr;
  logic [AW-1:0]      rd_bone [INFLUENCES];
  logic [DATA_W-1:0]  rd_data [INFLUENCES][ELEMS];
  logic signed [31:0] pos1 [3];
  logic signed [31:0] nrm1 [3];
  logic [7:0]         w1 [INFLUENCES];
  logic signed [63:0] term_p [INFLUENCES][3];
  logic signed [63:0] term_n [INFLUENCES][3];
  logic signed [63:0] acc [6];
  logic signed [63:0] sum [6];
  logic signed [31:0] res [6];

  // a stage moves when it is empty or the next one moves
  assign en[NS+1] = vout.ready;
  for (genvar s = 1; s <= NS; s++) begin : g_en
    assign en[s] = !v[s] || en[s+1];
  end

  assign vin.ready = en[1];

  always_comb begin
    pal_wr.en   = vin.valid && en[1] && (vin.op == OP_WRITE);
    pal_wr.slot = vin.matrix_slot;
    pal_wr.data = vin.matrix_value;
    for (int k = 0; k < INFLUENCES; k++) begin
      rd_bone[k] = vin.bone_indices[8*k +: AW];
    end
  end

  lbs_palette #(
    .BONE_COUNT (BONE_COUNT),
    .INFLUENCES (INFLUENCES),
    .AW         (AW)
  ) u_palette (
    .clk     (clk),
    .wr      (pal_wr),
    .rd_en   (en[1]),
    .rd_bone (rd_bone),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= vin.valid && (vin.op == OP_SKIN);
      for (int s = 2; s <= NS; s++) begin
        if (en[s]) v[s] <= v[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      pos1[0] <= vin.pos_x;
      pos1[1] <= vin.pos_y;
      pos1[2] <= vin.pos_z;
      nrm1[0] <= vin.norm_x;
      nrm1[1] <= vin.norm_y;
      nrm1[2] <= vin.norm_z;
      for (int k = 0; k < INFLUENCES; k++) begin
        // a bone outside the palette contributes nothing
        if ({1'b0, vin.bone_indices[8*k +: 8]} < 9'(BONE_COUNT))
          w1[k] <= vin.bone_weights[8*k +: 8];
        else
          w1[k] <= 8'd0;
      end
      last_q[1] <= vin.last_vertex;
    end
    for (int s = 2; s <= NS; s++) begin
      if (en[s]) last_q[s] <= last_q[s-1];
    end
    if (en[5]) acc <= sum;
  end

  for (genvar k = 0; k < INFLUENCES; k++) begin : g_xf
    lbs_xform #(
      .FRAC_BITS (FRAC_BITS)
    ) u_xform (
      .clk    (clk),
      .adv    (en[4:2]),
      .elem   (rd_data[k]),
      .pos    (pos1),
      .nrm    (nrm1),
      .w      (w1[k]),
      .term_p (term_p[k]),
      .term_n (term_n[k])
    );
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sum[j]   = '0;
      sum[3+j] = '0;
      for (int k = 0; k < INFLUENCES; k++) begin
        sum[j]   = sum[j] + term_p[k][j];
        sum[3+j] = sum[3+j] + term_n[k][j];
      end
    end
  end

  for (genvar c = 0; c < 6; c++) begin : g_norm
    lbs_norm u_norm (
      .clk (clk),
      .adv (en[7:6]),
      .acc (acc[c]),
      .res (res[c])
    );
  end

  assign vout.valid       = v[NS];
  assign vout.skin_pos_x  = res[0];
  assign vout.skin_pos_y  = res[1];
  assign vout.skin_pos_z  = res[2];
  assign vout.skin_norm_x = res[3];
  assign vout.skin_norm_y = res[4];
  assign vout.skin_norm_z = res[5];
  assign vout.end_of_mesh = last_q[NS];

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    ((&v) && !vout.ready) |-> !vin.ready)
    else $error("transaction accepted into a full stalled pipeline");

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (vin.valid && vin.ready && vin.op == OP_WRITE) |=> !v[1])
    else $error("palette write entered the vertex pipeline");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (v[3] && !en[3]) |=> (v[3] && v[4]))
    else $error("stalled vertex lost in the middle of the pipeline");

endmodule
`default_nettype wire
